// ===== hw/rtl/dns_message_stream_parser_assert.svh =====
// Assertion macros for the DNS message stream parser.
`ifndef DNS_MESSAGE_STREAM_PARSER_ASSERT_SVH
`define DNS_MESSAGE_STREAM_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DMSP_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define DMSP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define DMSP_ASSERT(lbl, cond, msg)
`define DMSP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/dmsp_pkg.sv =====
package dmsp_pkg;

    localparam logic [4:0] K_ID     = 5'd0;
    localparam logic [4:0] K_QR     = 5'd1;
    localparam logic [4:0] K_OPCODE = 5'd2;
    localparam logic [4:0] K_AA     = 5'd3;
    localparam logic [4:0] K_TC     = 5'd4;
    localparam logic [4:0] K_RD     = 5'd5;
    localparam logic [4:0] K_RA     = 5'd6;
    localparam logic [4:0] K_RCODE  = 5'd7;
    localparam logic [4:0] K_QD     = 5'd8;
    localparam logic [4:0] K_CHAR   = 5'd12;
    localparam logic [4:0] K_NEND   = 5'd13;
    localparam logic [4:0] K_TYPE   = 5'd14;
    localparam logic [4:0] K_CLASS  = 5'd15;
    localparam logic [4:0] K_TTL    = 5'd16;
    localparam logic [4:0] K_RDLEN  = 5'd17;
    localparam logic [4:0] K_RDATA  = 5'd18;
    localparam logic [4:0] K_DONE   = 5'd19;
    localparam logic [4:0] K_ERROR  = 5'd20;

    localparam logic [31:0] E_PTR  = 32'd1;
    localparam logic [31:0] E_OVR  = 32'd2;
    localparam logic [31:0] E_LONG = 32'd3;
    localparam logic [31:0] E_RSVD = 32'd4;

    localparam logic [3:0] PH_HEADER   = 4'd0;
    localparam logic [3:0] PH_NAME_LEN = 4'd1;
    localparam logic [3:0] PH_LABEL    = 4'd2;
    localparam logic [3:0] PH_PTR_LOW  = 4'd3;
    localparam logic [3:0] PH_TYPE     = 4'd4;
    localparam logic [3:0] PH_CLASS    = 4'd5;
    localparam logic [3:0] PH_TTL      = 4'd6;
    localparam logic [3:0] PH_RDLEN    = 4'd7;
    localparam logic [3:0] PH_RDATA    = 4'd8;
    localparam logic [3:0] PH_DONE     = 4'd9;
    localparam logic [3:0] PH_ERROR    = 4'd10;

    localparam logic [7:0] DOT_CHAR = 8'h2e;
    localparam int         Q_DEPTH  = 4;

    typedef struct packed {
        logic        is_question;
        logic [17:0] record_number;
        logic [31:0] token_value;
        logic [4:0]  token_kind;
        logic        last_of_run;
    } tok_t;

    function automatic logic [31:0] flag_value(input logic [4:0] kind, input logic [15:0] v);
        logic [31:0] r;
        r = 32'd0;
        case (kind)
            K_QR:     r = {31'd0, v[15]};
            K_OPCODE: r = {28'd0, v[14:11]};
            K_AA:     r = {31'd0, v[10]};
            K_TC:     r = {31'd0, v[9]};
            K_RD:     r = {31'd0, v[8]};
            K_RA:     r = {31'd0, v[7]};
            K_RCODE:  r = {28'd0, v[3:0]};
            default:  r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/dns_message_stream_parser.sv =====
// DNS message stream parser.
// The slave channel takes one message byte per beat in tdata; tuser set on a
// beat marks the first byte of a new message and clears the parser first.
// The master channel gives one token per beat: kind, value, record index and
// question flag in tdata, and tlast on the last token caused by an input byte.
// A byte that makes two tokens holds off the input while the second is given.
// The fourth header byte makes seven tokens, and the input is held off while
// the last six are given.
// A compression pointer walks the stored message through a single read port,
// reading each length byte, both pointer bytes and each character in turn and
// giving a dot after each label; no byte is taken during the walk.
// Tokens pass through a four-entry queue, so each token is registered in the
// queue before it is seen on the master side.
// When the receiver stalls, the queue fills and tready on the slave side drops;
// nothing is lost. Reset empties the queue and returns the parser to the header
// of a message; the message store is not cleared and needs no clearing pass.
`include "dns_message_stream_parser_assert.svh"

module dns_message_stream_parser #(
    parameter int MESSAGE_BYTES = 512,
    parameter int NAME_MAX      = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_packet
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [4:0] token_kind, [36:5] token_value,
                                   // [54:37] record_number, [55] is_question
    output logic        m_tlast
);

    localparam int AW = $clog2(MESSAGE_BYTES);

    logic           tok_push;
    dmsp_pkg::tok_t tok;
    dmsp_pkg::tok_t head;
    logic           q_full;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    dmsp_parser #(
        .MESSAGE_BYTES (MESSAGE_BYTES),
        .NAME_MAX      (NAME_MAX)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_sop    (s_tuser),
        .tok_push  (tok_push),
        .tok       (tok),
        .q_full    (q_full),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dmsp_ram #(
        .WIDTH (8),
        .DEPTH (MESSAGE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dmsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (tok_push),
        .din        (tok),
        .full       (q_full),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    assign m_tdata = {head.is_question, head.record_number, head.token_value, head.token_kind};
    assign m_tlast = head.last_of_run;

    `DMSP_ASSERT(a_no_push_full, !(tok_push && q_full), "token pushed into a full queue")
    `DMSP_ASSERT(a_port_conflict, !(ram_we && ram_re), "store written and read together")
    `DMSP_ASSERT_IMPL(a_error_last, tok_push && (tok.token_kind == dmsp_pkg::K_ERROR), tok.last_of_run, "error token not last of run")

endmodule

// ===== hw/rtl/dmsp_ram.sv =====
module dmsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/dmsp_queue.sv =====
module dmsp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dmsp_pkg::tok_t   din,
    output logic             full,
    output logic             head_valid,
    input  logic             head_ready,
    output dmsp_pkg::tok_t   head
);

    localparam int QAW = $clog2(dmsp_pkg::Q_DEPTH);
    localparam int QCW = $clog2(dmsp_pkg::Q_DEPTH + 1);

    dmsp_pkg::tok_t   mem_reg [dmsp_pkg::Q_DEPTH];
    logic [QAW-1:0]   wr_reg;
    logic [QAW-1:0]   rd_reg;
    logic [QCW-1:0]   cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (cnt_reg == QCW'(dmsp_pkg::Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_valid && head_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/dmsp_parser.sv =====
module dmsp_parser #(
    parameter int MESSAGE_BYTES = 512,
    parameter int NAME_MAX      = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_byte,
    input  logic                             in_sop,
    output logic                             tok_push,
    output dmsp_pkg::tok_t                   tok,
    input  logic                             q_full,
    output logic                             ram_we,
    output logic [$clog2(MESSAGE_BYTES)-1:0] ram_waddr,
    output logic [7:0]                       ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(MESSAGE_BYTES)-1:0] ram_raddr,
    input  logic [7:0]                       ram_rdata
);

    localparam int AW = $clog2(MESSAGE_BYTES);
    localparam int OW = $clog2(MESSAGE_BYTES + 1);
    localparam int PW = 17;

    localparam logic [2:0] S_IN    = 3'd0;
    localparam logic [2:0] S_FLAGS = 3'd1;
    localparam logic [2:0] S_EMIT2 = 3'd2;
    localparam logic [2:0] W_CHK   = 3'd3;
    localparam logic [2:0] W_LEN   = 3'd4;
    localparam logic [2:0] W_PLO   = 3'd5;
    localparam logic [2:0] W_CHR   = 3'd6;
    localparam logic [2:0] W_DOT   = 3'd7;

    logic [2:0]     seq_reg, seq_next;
    logic [3:0]     phase_reg, phase_next;
    logic [OW-1:0]  off_reg, off_next;
    logic [17:0]    rl_reg, rl_next;
    logic [15:0]    ql_reg, ql_next;
    logic [31:0]    acc_reg, acc_next;
    logic [15:0]    left_reg, left_next;
    logic [6:0]     nlen_reg, nlen_next;
    logic [5:0]     ptrhi_reg, ptrhi_next;
    logic [17:0]    rec_reg, rec_next;
    logic [4:0]     fk_reg, fk_next;
    dmsp_pkg::tok_t pend_reg, pend_next;
    logic [PW-1:0]  t_reg, t_next;
    logic [PW-1:0]  lim_reg, lim_next;
    logic [PW-1:0]  p_reg, p_next;
    logic [5:0]     clen_reg, clen_next;
    logic [5:0]     rem_reg, rem_next;
    logic [5:0]     chi_reg, chi_next;

    logic [3:0]     e_phase;
    logic [OW-1:0]  e_off;
    logic [17:0]    e_rl;
    logic [15:0]    e_ql;
    logic [31:0]    e_acc;
    logic [15:0]    e_left;
    logic [6:0]     e_nlen;
    logic [17:0]    e_rec;
    logic           e_q;
    logic           q_now;
    logic [31:0]    sh_acc;
    logic [15:0]    dec_left;
    logic [15:0]    fr_ql;
    logic [17:0]    fr_rl;
    logic [17:0]    fr_rec;
    logic [17:0]    hdr_rl;
    logic [3:0]     pos4;
    logic [7:0]     c;
    logic [PW-1:0]  nt;

    function automatic logic too_long(input logic [6:0] nl, input logic [5:0] len);
        logic [7:0] sum;
        sum = {1'b0, nl} + {2'b0, len} + 8'd1;
        return sum > 8'(NAME_MAX - 1);
    endfunction

    always_comb
    begin
        e_phase = in_sop ? dmsp_pkg::PH_HEADER : phase_reg;
        e_off   = in_sop ? '0 : off_reg;
        e_rl    = in_sop ? '0 : rl_reg;
        e_ql    = in_sop ? '0 : ql_reg;
        e_acc   = in_sop ? '0 : acc_reg;
        e_left  = in_sop ? '0 : left_reg;
        e_nlen  = in_sop ? '0 : nlen_reg;
        e_rec   = in_sop ? '0 : rec_reg;
        e_q     = (e_phase >= dmsp_pkg::PH_NAME_LEN) && (e_phase <= dmsp_pkg::PH_RDATA)
                  && (e_ql != '0);
        q_now   = (phase_reg >= dmsp_pkg::PH_NAME_LEN) && (phase_reg <= dmsp_pkg::PH_RDATA)
                  && (ql_reg != '0);
        sh_acc  = {e_acc[23:0], in_byte};
        dec_left = (e_left != '0) ? e_left - 16'd1 : e_left;
        fr_ql   = (e_ql != '0) ? e_ql - 16'd1 : e_ql;
        fr_rl   = (e_rl != '0) ? e_rl - 18'd1 : e_rl;
        fr_rec  = e_rec + 18'd1;
        hdr_rl  = e_rl + {2'b0, sh_acc[15:0]};
        pos4    = e_off[3:0];
        c       = ram_rdata;
        nt      = {3'b0, chi_reg, ram_rdata};

        seq_next   = seq_reg;
        phase_next = phase_reg;
        off_next   = off_reg;
        rl_next    = rl_reg;
        ql_next    = ql_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        nlen_next  = nlen_reg;
        ptrhi_next = ptrhi_reg;
        rec_next   = rec_reg;
        fk_next    = fk_reg;
        pend_next  = pend_reg;
        t_next     = t_reg;
        lim_next   = lim_reg;
        p_next     = p_reg;
        clen_next  = clen_reg;
        rem_next   = rem_reg;
        chi_next   = chi_reg;

        in_ready  = 1'b0;
        tok_push  = 1'b0;
        tok       = '0;
        ram_we    = 1'b0;
        ram_waddr = e_off[AW-1:0];
        ram_wdata = in_byte;
        ram_re    = 1'b0;
        ram_raddr = t_reg[AW-1:0];

        case (seq_reg)
            S_IN:
            begin
                in_ready = !q_full;
                tok.record_number = e_rec;
                tok.is_question   = e_q;
                tok.last_of_run   = 1'b1;
                if (in_valid && !q_full)
                begin
                    phase_next = e_phase;
                    off_next   = e_off;
                    rl_next    = e_rl;
                    ql_next    = e_ql;
                    acc_next   = e_acc;
                    left_next  = e_left;
                    nlen_next  = e_nlen;
                    rec_next   = e_rec;
                    ptrhi_next = in_sop ? '0 : ptrhi_reg;
                    if ((e_phase == dmsp_pkg::PH_DONE) || (e_phase == dmsp_pkg::PH_ERROR))
                    begin
                        // Message finished; the beat is dropped.
                    end
                    else if (e_off >= OW'(MESSAGE_BYTES))
                    begin
                        tok_push        = 1'b1;
                        tok.token_kind  = dmsp_pkg::K_ERROR;
                        tok.token_value = dmsp_pkg::E_OVR;
                        phase_next      = dmsp_pkg::PH_ERROR;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        off_next = e_off + 1'b1;
                        case (e_phase)
                            dmsp_pkg::PH_HEADER:
                            begin
                                acc_next = sh_acc;
                                tok.token_value = {16'd0, sh_acc[15:0]};
                                if (pos4 == 4'd1)
                                begin
                                    tok_push       = 1'b1;
                                    tok.token_kind = dmsp_pkg::K_ID;
                                end
                                else if (pos4 == 4'd3)
                                begin
                                    tok_push        = 1'b1;
                                    tok.token_kind  = dmsp_pkg::K_QR;
                                    tok.token_value = dmsp_pkg::flag_value(dmsp_pkg::K_QR,
                                                                           sh_acc[15:0]);
                                    tok.last_of_run = 1'b0;
                                    fk_next         = dmsp_pkg::K_OPCODE;
                                    seq_next        = S_FLAGS;
                                end
                                else if (pos4[0])
                                begin
                                    tok_push       = 1'b1;
                                    tok.token_kind = dmsp_pkg::K_QD + {2'b0, pos4[3:1]} - 5'd2;
                                    rl_next        = hdr_rl;
                                    if (pos4 == 4'd5)
                                    begin
                                        ql_next = sh_acc[15:0];
                                    end
                                    if (pos4 == 4'd11)
                                    begin
                                        rec_next  = '0;
                                        nlen_next = '0;
                                        if (hdr_rl == '0)
                                        begin
                                            phase_next      = dmsp_pkg::PH_DONE;
                                            tok.last_of_run = 1'b0;
                                            pend_next       = '0;
                                            pend_next.token_kind  = dmsp_pkg::K_DONE;
                                            pend_next.last_of_run = 1'b1;
                                            seq_next        = S_EMIT2;
                                        end
                                        else
                                        begin
                                            phase_next = dmsp_pkg::PH_NAME_LEN;
                                        end
                                    end
                                end
                            end
                            dmsp_pkg::PH_NAME_LEN:
                            begin
                                if (in_byte == 8'd0)
                                begin
                                    tok_push       = 1'b1;
                                    tok.token_kind = dmsp_pkg::K_NEND;
                                    phase_next     = dmsp_pkg::PH_TYPE;
                                    left_next      = 16'd2;
                                    acc_next       = '0;
                                end
                                else if (in_byte[7:6] == 2'b11)
                                begin
                                    ptrhi_next = in_byte[5:0];
                                    phase_next = dmsp_pkg::PH_PTR_LOW;
                                end
                                else if (in_byte[7:6] != 2'b00)
                                begin
                                    tok_push        = 1'b1;
                                    tok.token_kind  = dmsp_pkg::K_ERROR;
                                    tok.token_value = dmsp_pkg::E_RSVD;
                                    phase_next      = dmsp_pkg::PH_ERROR;
                                end
                                else if (too_long(e_nlen, in_byte[5:0]))
                                begin
                                    tok_push        = 1'b1;
                                    tok.token_kind  = dmsp_pkg::K_ERROR;
                                    tok.token_value = dmsp_pkg::E_LONG;
                                    phase_next      = dmsp_pkg::PH_ERROR;
                                end
                                else
                                begin
                                    left_next  = {8'd0, in_byte};
                                    phase_next = dmsp_pkg::PH_LABEL;
                                end
                            end
                            dmsp_pkg::PH_LABEL:
                            begin
                                tok_push        = 1'b1;
                                tok.token_kind  = dmsp_pkg::K_CHAR;
                                tok.token_value = {24'd0, in_byte};
                                nlen_next       = e_nlen + 7'd1;
                                left_next       = dec_left;
                                if (dec_left == '0)
                                begin
                                    tok.last_of_run = 1'b0;
                                    nlen_next       = e_nlen + 7'd2;
                                    phase_next      = dmsp_pkg::PH_NAME_LEN;
                                    pend_next       = tok;
                                    pend_next.token_value = {24'd0, dmsp_pkg::DOT_CHAR};
                                    pend_next.last_of_run = 1'b1;
                                    seq_next        = S_EMIT2;
                                end
                            end
                            dmsp_pkg::PH_PTR_LOW:
                            begin
                                t_next   = {3'b0, ptrhi_reg, in_byte};
                                lim_next = PW'(e_off) - 17'd1;
                                seq_next = W_CHK;
                            end
                            dmsp_pkg::PH_RDATA:
                            begin
                                tok_push        = 1'b1;
                                tok.token_kind  = dmsp_pkg::K_RDATA;
                                tok.token_value = {24'd0, in_byte};
                                left_next       = dec_left;
                                if (dec_left == '0)
                                begin
                                    ql_next   = fr_ql;
                                    rl_next   = fr_rl;
                                    rec_next  = fr_rec;
                                    nlen_next = '0;
                                    if (fr_rl == '0)
                                    begin
                                        phase_next      = dmsp_pkg::PH_DONE;
                                        tok.last_of_run = 1'b0;
                                        pend_next       = '0;
                                        pend_next.token_kind    = dmsp_pkg::K_DONE;
                                        pend_next.token_value   = {14'd0, fr_rec};
                                        pend_next.record_number = fr_rec;
                                        pend_next.last_of_run   = 1'b1;
                                        seq_next        = S_EMIT2;
                                    end
                                    else
                                    begin
                                        phase_next = dmsp_pkg::PH_NAME_LEN;
                                    end
                                end
                            end
                            dmsp_pkg::PH_TYPE, dmsp_pkg::PH_CLASS,
                            dmsp_pkg::PH_TTL, dmsp_pkg::PH_RDLEN:
                            begin
                                acc_next  = sh_acc;
                                left_next = dec_left;
                                if (dec_left == '0)
                                begin
                                    tok_push        = 1'b1;
                                    tok.token_value = {16'd0, sh_acc[15:0]};
                                    acc_next        = '0;
                                    case (e_phase)
                                        dmsp_pkg::PH_TYPE:
                                        begin
                                            tok.token_kind = dmsp_pkg::K_TYPE;
                                            phase_next     = dmsp_pkg::PH_CLASS;
                                            left_next      = 16'd2;
                                        end
                                        dmsp_pkg::PH_TTL:
                                        begin
                                            tok.token_kind  = dmsp_pkg::K_TTL;
                                            tok.token_value = sh_acc;
                                            phase_next      = dmsp_pkg::PH_RDLEN;
                                            left_next       = 16'd2;
                                        end
                                        default:
                                        begin
                                            tok.token_kind = (e_phase == dmsp_pkg::PH_CLASS) ?
                                                             dmsp_pkg::K_CLASS :
                                                             dmsp_pkg::K_RDLEN;
                                            if ((e_phase == dmsp_pkg::PH_CLASS) && (e_ql == '0))
                                            begin
                                                phase_next = dmsp_pkg::PH_TTL;
                                                left_next  = 16'd4;
                                            end
                                            else if ((e_phase == dmsp_pkg::PH_RDLEN)
                                                     && (sh_acc[15:0] != '0))
                                            begin
                                                phase_next = dmsp_pkg::PH_RDATA;
                                                left_next  = sh_acc[15:0];
                                            end
                                            else
                                            begin
                                                ql_next   = fr_ql;
                                                rl_next   = fr_rl;
                                                rec_next  = fr_rec;
                                                nlen_next = '0;
                                                if (fr_rl == '0)
                                                begin
                                                    phase_next      = dmsp_pkg::PH_DONE;
                                                    tok.last_of_run = 1'b0;
                                                    pend_next       = '0;
                                                    pend_next.token_kind    = dmsp_pkg::K_DONE;
                                                    pend_next.token_value   = {14'd0, fr_rec};
                                                    pend_next.record_number = fr_rec;
                                                    pend_next.last_of_run   = 1'b1;
                                                    seq_next        = S_EMIT2;
                                                end
                                                else
                                                begin
                                                    phase_next = dmsp_pkg::PH_NAME_LEN;
                                                end
                                            end
                                        end
                                    endcase
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_FLAGS:
            begin
                if (!q_full)
                begin
                    tok_push          = 1'b1;
                    tok.token_kind    = fk_reg;
                    tok.token_value   = dmsp_pkg::flag_value(fk_reg, acc_reg[15:0]);
                    tok.record_number = rec_reg;
                    tok.is_question   = q_now;
                    tok.last_of_run   = (fk_reg == dmsp_pkg::K_RCODE);
                    fk_next           = fk_reg + 5'd1;
                    if (fk_reg == dmsp_pkg::K_RCODE)
                    begin
                        seq_next = S_IN;
                    end
                end
            end
            S_EMIT2:
            begin
                if (!q_full)
                begin
                    tok_push = 1'b1;
                    tok      = pend_reg;
                    seq_next = S_IN;
                end
            end
            default:
            begin
                tok.record_number = rec_reg;
                tok.is_question   = q_now;
                tok.token_kind    = dmsp_pkg::K_ERROR;
                tok.token_value   = dmsp_pkg::E_PTR;
                tok.last_of_run   = 1'b1;
                if (!q_full)
                begin
                    case (seq_reg)
                        W_CHK:
                        begin
                            if (t_reg >= lim_reg)
                            begin
                                tok_push = 1'b1;
                            end
                            else
                            begin
                                ram_re   = 1'b1;
                                seq_next = W_LEN;
                            end
                        end
                        W_LEN:
                        begin
                            ram_raddr = AW'(t_reg + 17'd1);
                            if (c == 8'd0)
                            begin
                                tok_push       = 1'b1;
                                tok.token_kind = dmsp_pkg::K_NEND;
                                tok.token_value = '0;
                            end
                            else if (c[7:6] == 2'b11)
                            begin
                                if ((t_reg + 17'd1) >= lim_reg)
                                begin
                                    tok_push = 1'b1;
                                end
                                else
                                begin
                                    ram_re   = 1'b1;
                                    chi_next = c[5:0];
                                    seq_next = W_PLO;
                                end
                            end
                            else if (c[7:6] != 2'b00)
                            begin
                                tok_push        = 1'b1;
                                tok.token_value = dmsp_pkg::E_RSVD;
                            end
                            else if (too_long(nlen_reg, c[5:0]))
                            begin
                                tok_push        = 1'b1;
                                tok.token_value = dmsp_pkg::E_LONG;
                            end
                            else if ((t_reg + {11'd0, c[5:0]}) >= lim_reg)
                            begin
                                tok_push = 1'b1;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                p_next    = t_reg + 17'd1;
                                rem_next  = c[5:0];
                                clen_next = c[5:0];
                                seq_next  = W_CHR;
                            end
                        end
                        W_PLO:
                        begin
                            if (nt >= t_reg)
                            begin
                                tok_push = 1'b1;
                            end
                            else
                            begin
                                t_next   = nt;
                                seq_next = W_CHK;
                            end
                        end
                        W_CHR:
                        begin
                            tok_push        = 1'b1;
                            tok.token_kind  = dmsp_pkg::K_CHAR;
                            tok.token_value = {24'd0, ram_rdata};
                            tok.last_of_run = 1'b0;
                            ram_raddr       = AW'(p_reg + 17'd1);
                            if (rem_reg == 6'd1)
                            begin
                                seq_next = W_DOT;
                            end
                            else
                            begin
                                ram_re   = 1'b1;
                                p_next   = p_reg + 17'd1;
                                rem_next = rem_reg - 6'd1;
                            end
                        end
                        default:
                        begin
                            tok_push        = 1'b1;
                            tok.token_kind  = dmsp_pkg::K_CHAR;
                            tok.token_value = {24'd0, dmsp_pkg::DOT_CHAR};
                            tok.last_of_run = 1'b0;
                            nlen_next       = nlen_reg + {1'b0, clen_reg} + 7'd1;
                            t_next          = t_reg + {11'd0, clen_reg} + 17'd1;
                            seq_next        = W_CHK;
                        end
                    endcase
                    if (tok_push && tok.last_of_run)
                    begin
                        seq_next = S_IN;
                        if (tok.token_kind == dmsp_pkg::K_NEND)
                        begin
                            phase_next = dmsp_pkg::PH_TYPE;
                            left_next  = 16'd2;
                            acc_next   = '0;
                        end
                        else
                        begin
                            phase_next = dmsp_pkg::PH_ERROR;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        t_reg    <= t_next;
        lim_reg  <= lim_next;
        p_reg    <= p_next;
        clen_reg <= clen_next;
        rem_reg  <= rem_next;
        chi_reg  <= chi_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= S_IN;
            phase_reg <= dmsp_pkg::PH_HEADER;
            off_reg   <= '0;
            rl_reg    <= '0;
            ql_reg    <= '0;
            acc_reg   <= '0;
            left_reg  <= '0;
            nlen_reg  <= '0;
            ptrhi_reg <= '0;
            rec_reg   <= '0;
            fk_reg    <= dmsp_pkg::K_OPCODE;
        end
        else
        begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
            off_reg   <= off_next;
            rl_reg    <= rl_next;
            ql_reg    <= ql_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            nlen_reg  <= nlen_next;
            ptrhi_reg <= ptrhi_next;
            rec_reg   <= rec_next;
            fk_reg    <= fk_next;
        end
    end

endmodule
